[rtl/tsdr_pkg.sv]
// Package: shared types, constants and command codes for the triangle rasterizer.
`timescale 1ns / 1ps
package tsdr_pkg;

  localparam int DEF_SCREEN_WIDTH  = 128;
  localparam int DEF_SCREEN_HEIGHT = 64;
  localparam int DEF_ASPECT_RATIO  = 2;
  localparam int SCALE_Q16         = 58982;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic signed [15:0] bz;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;
    logic [3:0]         shade;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         pixel_shade;
    logic signed [15:0] pixel_depth;
  } out_item_t;

  // Mapped Q.8 vertex: x, y and depth.
  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [15:0] z;
  } vtx_t;

  // Classified job handed from front to back.
  typedef struct packed {
    logic [1:0]  kind;
    vtx_t        v0;
    vtx_t        v1;
    vtx_t        v2;
    logic [3:0]  shade;
    logic signed [15:0] rcol;
    logic signed [15:0] rrow;
  } job_t;

  typedef enum logic [1:0] {
    FS_IDLE = 2'd0,
    FS_MAP  = 2'd1,
    FS_SORT = 2'd2,
    FS_PUSH = 2'd3
  } front_state_t;

  typedef enum logic [3:0] {
    BS_IDLE   = 4'd0,
    BS_CLEAR  = 4'd1,
    BS_SETUP  = 4'd2,
    BS_DIVGO  = 4'd3,
    BS_DIVW   = 4'd4,
    BS_ROW    = 4'd5,
    BS_PIXRD  = 4'd6,
    BS_PIXWR  = 4'd7,
    BS_STEP   = 4'd8,
    BS_READ   = 4'd9,
    BS_READW  = 4'd10,
    BS_OUT    = 4'd11
  } back_state_t;

endpackage

[rtl/triangle_scanline_depth_raster.sv]
// Top level of the scanline triangle rasterizer with depth store.
// Usage:
//  Drive cmd with start high while busy is low; the item is taken at that edge.
//  Commands: clear (blank every pixel), draw (fill a flat-shaded triangle with
//  a depth test against the top vertex depth) and read (return one pixel).
//  A read returns one result on res, marked by done for exactly one cycle;
//  the receiver must take it then, it cannot stall the block.
//  The front unit maps and sorts the vertices of a draw item, and queues up
//  to two jobs ahead of the back unit. The back unit sets the pace: a clear
//  writes one pixel per cycle (8192 by default), a draw takes up to three
//  slope divisions and then reads and depth-tests each covered pixel, row by
//  row, and a read fetches one pixel from the store.
//  After reset the back unit sweeps the store blank, one pixel a cycle;
//  items still queue, and are carried out once the sweep ends.
`timescale 1ns / 1ps
module triangle_scanline_depth_raster
  import tsdr_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
  parameter int ASPECT_RATIO  = DEF_ASPECT_RATIO
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  cmd,
  output logic      busy,
  output logic      done,
  output out_item_t res
);
  logic q_valid, q_pop;
  job_t q_job;

  tsdr_front #(.SCREEN_HEIGHT(SCREEN_HEIGHT), .ASPECT_RATIO(ASPECT_RATIO)) u_front (
    .clk, .rst, .start, .cmd_in(cmd), .busy, .q_valid, .q_job, .q_pop
  );

  tsdr_back #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_back (
    .clk, .rst, .q_valid, .q_job, .q_pop, .done, .result(res)
  );

`ifndef SYNTH
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("job popped from empty queue");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
`endif
endmodule

[rtl/tsdr_ram.sv]
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module tsdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry a cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[rtl/tsdr_div.sv]
// Iterative signed divider, one quotient bit a cycle, quotient truncated toward zero.
`timescale 1ns / 1ps
module tsdr_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic signed [25:0] num,
  input  logic signed [25:0] den,
  output logic               done,
  output logic signed [25:0] quo
);
  logic [25:0] rem, q, d;
  logic [4:0]  cnt;
  logic        neg, run;
  logic [26:0] trial;

  assign trial = {rem[24:0], q[25]} - {1'b0, d};

  // Restoring division on magnitudes.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= 5'd0;
        rem <= '0;
        q   <= num[25] ? -num : num;
        d   <= den[25] ? -den : den;
        neg <= num[25] ^ den[25];
      end else if (run) begin
        if (!trial[26]) begin
          rem <= trial[25:0];
          q   <= {q[24:0], 1'b1};
        end else begin
          rem <= {rem[24:0], q[25]};
          q   <= {q[24:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd25) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = neg ? -q : q;
endmodule

[rtl/tsdr_front.sv]
// Front part: accept commands, map and sort vertices, queue jobs for the back part.
`timescale 1ns / 1ps
module tsdr_front
  import tsdr_pkg::*;
#(
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
  parameter int ASPECT_RATIO  = DEF_ASPECT_RATIO
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  in_item_t cmd_in,
  output logic     busy,
  output logic     q_valid,
  output job_t     q_job,
  input  logic     q_pop
);
  localparam int XS = SCREEN_HEIGHT * ASPECT_RATIO / 2;
  localparam int YS = SCREEN_HEIGHT / 2;
  localparam int QD = 2;

  front_state_t state, state_next;
  in_item_t     item;
  logic [1:0]   mcnt;
  vtx_t         vt [3];
  job_t         q_mem [QD];
  logic         wp, rp;
  logic [1:0]   fill;
  logic         push;

  // Map one coordinate: floor(v*S*0.9 in Q.16 / 2^22) + S*256.
  function automatic logic signed [23:0] map_c(input logic signed [15:0] v,
                                              input logic [15:0] s);
    logic signed [48:0] p;
    p = 49'(v) * $signed({1'b0, 16'(s) * 32'(SCALE_Q16)});
    return 24'(p >>> 22) + 24'(s) * 24'd256;
  endfunction

  logic signed [15:0] sx, sy, sz;
  always_comb begin
    case (mcnt)
      2'd0: begin sx = item.ax; sy = item.ay; sz = item.az; end
      2'd1: begin sx = item.bx; sy = item.by; sz = item.bz; end
      default: begin sx = item.cx; sy = item.cy; sz = item.cz; end
    endcase
  end

  // Front control.
  always_comb begin
    state_next = state;
    push = 1'b0;
    case (state)
      FS_IDLE: if (start) state_next = (start && cmd_in.command == CMD_DRAW) ? FS_MAP : FS_PUSH;
      FS_MAP:  if (mcnt == 2'd2) state_next = FS_SORT;
      FS_SORT: state_next = FS_PUSH;
      FS_PUSH: if (fill < 2'(QD)) begin
        push = 1'b1;
        state_next = FS_IDLE;
      end
      default: state_next = FS_IDLE;
    endcase
  end

  assign busy = (state != FS_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the item, map one vertex a cycle, then sort by row.
  always_ff @(posedge clk) begin
    if (state == FS_IDLE && start) begin
      item <= cmd_in;
      mcnt <= 2'd0;
    end else if (state == FS_MAP) begin
      vt[mcnt].x <= map_c(sx, 16'(XS));
      vt[mcnt].y <= map_c(sy, 16'(YS));
      vt[mcnt].z <= sz;
      mcnt <= mcnt + 2'd1;
    end else if (state == FS_SORT) begin
      vtx_t a, b, c, t;
      a = vt[0]; b = vt[1]; c = vt[2];
      if (a.y > c.y) begin t = a; a = c; c = t; end
      if (b.y > c.y) begin t = b; b = c; c = t; end
      if (a.y > b.y) begin t = a; a = b; b = t; end
      vt[0] <= a; vt[1] <= b; vt[2] <= c;
    end
  end

  // Two-entry job queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (q_pop) begin
        rp <= ~rp;
      end
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wp].kind  <= item.command;
      q_mem[wp].v0    <= vt[0];
      q_mem[wp].v1    <= vt[1];
      q_mem[wp].v2    <= vt[2];
      q_mem[wp].shade <= item.shade;
      q_mem[wp].rcol  <= item.ax;
      q_mem[wp].rrow  <= item.ay;
    end
  end

  assign q_valid = (fill != 2'd0);
  assign q_job   = q_mem[rp];
endmodule

[rtl/tsdr_back.sv]
// Back part: clear, scanline walk with depth test, and pixel read.
`timescale 1ns / 1ps
module tsdr_back
  import tsdr_pkg::*;
#(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  job_t      q_job,
  output logic      q_pop,
  output logic      done,
  output out_item_t result
);
  localparam int NPIX = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW   = $clog2(NPIX);
  localparam logic signed [25:0] XMAX = 26'((SCREEN_WIDTH - 1) * 256);

  back_state_t state, state_next;
  job_t        job;
  logic signed [25:0] beg, mid, fin, last, y, x, rx;
  logic signed [25:0] xf, xh, sfull, shalf;
  logic [1:0]  dstep;
  logic        div_go, div_done;
  logic signed [25:0] dnum, dden, dquo;
  logic [AW-1:0] clr_a, addr;
  logic        we;
  logic [3:0]  sh_w, sh_r;
  logic [15:0] dp_w, dp_r;

  function automatic logic signed [25:0] tr8(input logic signed [25:0] v);
    return v[25] ? -26'((-v) >>> 8) : 26'(v >>> 8);
  endfunction

  tsdr_div u_div (.clk, .rst, .go(div_go), .num(dnum), .den(dden),
                  .done(div_done), .quo(dquo));

  tsdr_ram #(.WIDTH(4),  .DEPTH(NPIX)) u_shade (.clk, .we, .addr, .wdata(sh_w), .rdata(sh_r));
  tsdr_ram #(.WIDTH(16), .DEPTH(NPIX)) u_depth (.clk, .we, .addr, .wdata(dp_w), .rdata(dp_r));

  logic signed [25:0] lo, hi;
  always_comb begin
    lo = (xf < xh) ? xf : xh;
    hi = (xf > xh) ? xf : xh;
    if (lo < 0) lo = 0;
    if (hi > XMAX) hi = XMAX;
  end

  logic signed [31:0] pidx;
  assign pidx = 32'(y) * 32'(SCREEN_WIDTH) + 32'(x);

  // Memory port select.
  always_comb begin
    we   = 1'b0;
    sh_w = job.shade;
    dp_w = job.v0.z;
    addr = AW'(pidx);
    if (state == BS_CLEAR) begin
      we = 1'b1; sh_w = '0; dp_w = '0; addr = clr_a;
    end else if (state == BS_PIXWR) begin
      we = (sh_r == 4'd0) || ($signed(job.v0.z) > $signed(dp_r));
    end else if (state == BS_READ || state == BS_READW) begin
      addr = AW'(32'(job.rrow) * 32'(SCREEN_WIDTH) + 32'(job.rcol));
    end
  end

  // Slope operands per division step.
  always_comb begin
    case (dstep)
      2'd0: begin dnum = job.v0.x - job.v2.x; dden = beg - fin; end
      2'd1: begin dnum = job.v0.x - job.v1.x; dden = beg - mid; end
      default: begin dnum = job.v1.x - job.v2.x; dden = mid - fin; end
    endcase
  end

  logic in_scr;
  assign in_scr = !job.rcol[15] && !job.rrow[15] && (job.rcol < 16'(SCREEN_WIDTH))
                  && (job.rrow < 16'(SCREEN_HEIGHT));

  // Back control.
  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    div_go = 1'b0;
    case (state)
      BS_IDLE: if (q_valid) begin
        q_pop = 1'b1;
        case (q_job.kind)
          CMD_CLEAR: state_next = BS_CLEAR;
          CMD_DRAW:  state_next = BS_SETUP;
          CMD_READ:  state_next = BS_READ;
          default:   state_next = BS_IDLE;
        endcase
      end
      BS_CLEAR: if (clr_a == AW'(NPIX - 1)) state_next = BS_IDLE;
      BS_SETUP: state_next = BS_DIVGO;
      BS_DIVGO: begin
        if (dden == 0) begin
          state_next = (dstep == 2'd1) ? BS_ROW : BS_DIVGO;
        end else begin
          div_go = 1'b1;
          state_next = BS_DIVW;
        end
      end
      BS_DIVW: if (div_done) state_next = (dstep == 2'd2) ? BS_STEP : 
                                          ((dstep == 2'd1) ? BS_ROW : BS_DIVGO);
      BS_ROW: begin
        if (y > last) state_next = BS_IDLE;
        else if (y < 0 || tr8(lo) > tr8(hi)) state_next = BS_STEP;
        else state_next = BS_PIXRD;
      end
      BS_PIXRD: state_next = BS_PIXWR;
      BS_PIXWR: state_next = (x >= rx) ? BS_STEP : BS_PIXRD;
      BS_STEP: begin
        if (y == mid && dstep != 2'd2) begin
          if (mid == fin) state_next = BS_STEP;
          else state_next = BS_DIVGO;
        end else state_next = BS_ROW;
      end
      BS_READ:  state_next = in_scr ? BS_READW : BS_OUT;
      BS_READW: state_next = BS_OUT;
      BS_OUT:   state_next = BS_IDLE;
      default:  state_next = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BS_CLEAR;
      clr_a <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == BS_OUT);
      if (state == BS_CLEAR) clr_a <= clr_a + AW'(1);
      else clr_a <= '0;
    end
  end

  // Datapath: job capture, the walk and the read result.
  always_ff @(posedge clk) begin
    case (state)
      BS_IDLE: if (q_valid) job <= q_job;
      BS_SETUP: begin
        beg <= tr8(26'(job.v0.y));
        mid <= tr8(26'(job.v1.y));
        fin <= tr8(26'(job.v2.y));
        last <= (tr8(26'(job.v2.y)) < 26'(SCREEN_HEIGHT - 1)) ? tr8(26'(job.v2.y))
                : 26'(SCREEN_HEIGHT - 1);
        y <= tr8(26'(job.v0.y));
        xf <= 26'(job.v0.x);
        xh <= 26'(job.v0.x);
        sfull <= '0;
        shalf <= '0;
        dstep <= 2'd0;
      end
      BS_DIVGO: if (dden == 0 && dstep == 2'd0) dstep <= dstep + 2'd1;
      BS_DIVW: if (div_done) begin
        case (dstep)
          2'd0: sfull <= dquo;
          default: shalf <= dquo;
        endcase
        if (dstep == 2'd0) dstep <= dstep + 2'd1;
      end
      BS_ROW: begin
        x  <= tr8(lo);
        rx <= tr8(hi);
      end
      BS_PIXWR: x <= x + 26'd1;
      BS_STEP: begin
        if (y == mid && dstep != 2'd2) begin
          dstep <= 2'd2;
          shalf <= '0;
        end else begin
          xf <= xf + sfull;
          xh <= xh + shalf;
          y  <= y + 26'd1;
        end
      end
      BS_OUT: begin
        result.pixel_shade <= in_scr ? sh_r : 4'd0;
        result.pixel_depth <= in_scr ? dp_r : 16'sd0;
      end
      default: ;
    endcase
  end
endmodule
